>>> hdl/pbrr_pkg.sv
`timescale 1ns / 1ps
package pbrr_pkg;

  localparam int unsigned NumEntries = 64;
  localparam int unsigned NumLevels  = 4;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned BudW       = 6;
  localparam int unsigned LvlW       = 2;

  typedef enum logic [1:0] {
    OP_SET_RUN  = 2'd0,
    OP_SET_PRIO = 2'd1,
    OP_PICK     = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  localparam logic [1:0] CFG_BUD_ONE   = 2'd0;
  localparam logic [1:0] CFG_BUD_TWO   = 2'd1;
  localparam logic [1:0] CFG_BUD_THREE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFILL,
    ST_RESCAN,
    ST_LVL0,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the input item
    logic       do_set;    // apply a set operation
    logic       scan;      // search the current level
    logic       refill;    // refill the current level
    logic       charge;    // charge the winner and move the pointer
    logic       lvl0;      // pick from level 0
    logic       next_lvl;  // step down one level
    logic       clr_res;   // clear the result
  } cmd_t;

  typedef struct packed {
    op_e        op;
    logic       found;     // last scan found an entry
    logic       any;       // level has runnable entries
    logic       last_lvl;  // current level is 1
  } sts_t;

endpackage

>>> hdl/pbrr_datapath.sv
`timescale 1ns / 1ps
module pbrr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pbrr_pkg::cmd_t                 cmd_i,
  output pbrr_pkg::sts_t                 sts_o,
  input  logic [1:0]                     opcode_i,
  input  logic [pbrr_pkg::IdxW-1:0]      entry_index_i,
  input  logic                           runnable_value_i,
  input  logic [pbrr_pkg::LvlW-1:0]      new_priority_i,
  input  logic [pbrr_pkg::BudW-1:0]      bud_one_i,
  input  logic [pbrr_pkg::BudW-1:0]      bud_two_i,
  input  logic [pbrr_pkg::BudW-1:0]      bud_three_i,
  output logic                           pick_found_o,
  output logic [pbrr_pkg::IdxW-1:0]      picked_index_o,
  output logic [pbrr_pkg::LvlW-1:0]      picked_priority_o,
  output logic [pbrr_pkg::BudW-1:0]      budget_left_o
);
  localparam int unsigned N = pbrr_pkg::NumEntries;

  logic [N-1:0]                  run_q;
  logic [pbrr_pkg::LvlW-1:0]     prio_q [N];
  logic [pbrr_pkg::BudW-1:0]     bud_q  [N];
  logic [pbrr_pkg::IdxW-1:0]     ptr_q  [pbrr_pkg::NumLevels];
  logic [1:0]                    op_q;
  logic [pbrr_pkg::IdxW-1:0]     idx_q;
  logic                          rv_q;
  logic [pbrr_pkg::LvlW-1:0]     np_q;
  logic [pbrr_pkg::LvlW-1:0]     lvl_q;
  logic                          found_q;
  logic [pbrr_pkg::IdxW-1:0]     win_q;
  logic                          res_f_q;
  logic [pbrr_pkg::IdxW-1:0]     res_i_q;
  logic [pbrr_pkg::LvlW-1:0]     res_p_q;
  logic [pbrr_pkg::BudW-1:0]     res_b_q;

  logic [N-1:0] lvl_mask, elig, rot;
  logic [N-1:0] z_mask;
  logic         scan_hit, lvl0_hit;
  logic [pbrr_pkg::IdxW-1:0] rot_first, scan_idx, lvl0_idx;
  logic [pbrr_pkg::BudW-1:0] lvl_bud, set_bud;

  function automatic logic [pbrr_pkg::BudW-1:0] bud_of(input logic [1:0] l,
      input logic [pbrr_pkg::BudW-1:0] b1, input logic [pbrr_pkg::BudW-1:0] b2,
      input logic [pbrr_pkg::BudW-1:0] b3);
    logic [pbrr_pkg::BudW-1:0] r;
    case (l)
      2'd0:    r = '0;
      2'd1:    r = b1;
      2'd2:    r = b2;
      default: r = b3;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < N; k++) begin
      lvl_mask[k] = run_q[k] && (prio_q[k] == lvl_q);
      elig[k]     = lvl_mask[k] && (bud_q[k] != '0);
      z_mask[k]   = run_q[k] && (prio_q[k] == '0);
    end
    // Rotate so that the level's pointer lands at bit 0.
    rot = (elig >> ptr_q[lvl_q]) | (elig << (N[pbrr_pkg::IdxW:0] - {1'b0, ptr_q[lvl_q]}));
    rot_first = '0;
    for (int k = N-1; k >= 0; k--) begin
      if (rot[k]) rot_first = k[pbrr_pkg::IdxW-1:0];
    end
    scan_hit = |elig;
    scan_idx = rot_first + ptr_q[lvl_q];
    lvl0_hit = |z_mask;
    lvl0_idx = '0;
    for (int k = N-1; k >= 0; k--) begin
      if (z_mask[k]) lvl0_idx = k[pbrr_pkg::IdxW-1:0];
    end
    lvl_bud = bud_of(lvl_q, bud_one_i, bud_two_i, bud_three_i);
    set_bud = bud_of(np_q, bud_one_i, bud_two_i, bud_three_i);
  end

  assign sts_o.op       = pbrr_pkg::op_e'(op_q);
  assign sts_o.found    = found_q;
  assign sts_o.any      = |lvl_mask;
  assign sts_o.last_lvl = (lvl_q == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      for (int k = 0; k < N; k++) begin
        prio_q[k] <= 2'd2;
        bud_q[k]  <= 6'd16;
      end
      for (int l = 0; l < pbrr_pkg::NumLevels; l++) ptr_q[l] <= '0;
      op_q    <= '0;
      idx_q   <= '0;
      rv_q    <= 1'b0;
      np_q    <= '0;
      lvl_q   <= 2'd3;
      found_q <= 1'b0;
      win_q   <= '0;
      res_f_q <= 1'b0;
      res_i_q <= '0;
      res_p_q <= '0;
      res_b_q <= '0;
    end else begin
      if (cmd_i.load) begin
        op_q  <= opcode_i;
        idx_q <= entry_index_i;
        rv_q  <= runnable_value_i;
        np_q  <= new_priority_i;
        lvl_q <= 2'd3;
      end
      if (cmd_i.do_set) begin
        if (op_q == pbrr_pkg::OP_SET_RUN) run_q[idx_q] <= rv_q;
        if (op_q == pbrr_pkg::OP_SET_PRIO) begin
          prio_q[idx_q] <= np_q;
          bud_q[idx_q]  <= set_bud;
        end
      end
      if (cmd_i.scan) begin
        found_q <= scan_hit;
        win_q   <= scan_idx;
      end
      if (cmd_i.refill) begin
        for (int k = 0; k < N; k++) begin
          if (lvl_mask[k] && bud_q[k] == '0) bud_q[k] <= lvl_bud;
        end
      end
      if (cmd_i.next_lvl) lvl_q <= lvl_q - 2'd1;
      if (cmd_i.clr_res) begin
        res_f_q <= 1'b0;
        res_i_q <= '0;
        res_p_q <= '0;
        res_b_q <= '0;
      end
      if (cmd_i.charge) begin
        bud_q[win_q] <= bud_q[win_q] - 6'd1;
        ptr_q[lvl_q] <= win_q + 6'd1;
        res_f_q      <= 1'b1;
        res_i_q      <= win_q;
        res_p_q      <= lvl_q;
        res_b_q      <= bud_q[win_q] - 6'd1;
      end
      if (cmd_i.lvl0) begin
        res_f_q <= lvl0_hit;
        res_i_q <= lvl0_idx;
        res_p_q <= '0;
        res_b_q <= '0;
      end
    end
  end

  assign pick_found_o      = res_f_q;
  assign picked_index_o    = res_i_q;
  assign picked_priority_o = res_p_q;
  assign budget_left_o     = res_b_q;

endmodule

>>> hdl/pbrr_ctrl.sv
`timescale 1ns / 1ps
module pbrr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pbrr_pkg::sts_t  sts_i,
  output pbrr_pkg::cmd_t  cmd_o
);
  pbrr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pbrr_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pbrr_pkg::ST_IDLE:
        if (in_valid_i) state_d = pbrr_pkg::ST_SCAN;
      pbrr_pkg::ST_SCAN: begin
        if (sts_i.op != pbrr_pkg::OP_PICK) state_d = pbrr_pkg::ST_OUT;
        else                               state_d = pbrr_pkg::ST_REFILL;
      end
      pbrr_pkg::ST_REFILL: begin
        if (sts_i.found)      state_d = pbrr_pkg::ST_OUT;
        else if (sts_i.any)   state_d = pbrr_pkg::ST_RESCAN;
        else if (sts_i.last_lvl) state_d = pbrr_pkg::ST_OUT;
        else                  state_d = pbrr_pkg::ST_SCAN;
      end
      pbrr_pkg::ST_RESCAN:
        state_d = pbrr_pkg::ST_LVL0;
      pbrr_pkg::ST_LVL0: begin
        if (sts_i.found)         state_d = pbrr_pkg::ST_OUT;
        else if (sts_i.last_lvl) state_d = pbrr_pkg::ST_OUT;
        else                     state_d = pbrr_pkg::ST_SCAN;
      end
      pbrr_pkg::ST_OUT:
        if (out_ready_i) state_d = pbrr_pkg::ST_IDLE;
      default: state_d = pbrr_pkg::ST_IDLE;
    endcase
  end

  // SCAN applies sets or searches; RESCAN searches again; REFILL and
  // LVL0 charge a find, refill (REFILL), step down or pick level 0.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      pbrr_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
        cmd_o.clr_res = in_valid_i;
      end
      pbrr_pkg::ST_SCAN: begin
        cmd_o.do_set = 1'b1;
        cmd_o.scan   = (sts_i.op == pbrr_pkg::OP_PICK);
      end
      pbrr_pkg::ST_REFILL: begin
        cmd_o.charge = sts_i.found;
        cmd_o.refill = !sts_i.found && sts_i.any;
        cmd_o.next_lvl = !sts_i.found && !sts_i.any && !sts_i.last_lvl;
        cmd_o.lvl0   = !sts_i.found && !sts_i.any && sts_i.last_lvl;
      end
      pbrr_pkg::ST_RESCAN:
        cmd_o.scan = 1'b1;
      pbrr_pkg::ST_LVL0: begin
        cmd_o.charge   = sts_i.found;
        cmd_o.next_lvl = !sts_i.found && !sts_i.last_lvl;
        cmd_o.lvl0     = !sts_i.found && sts_i.last_lvl;
      end
      pbrr_pkg::ST_OUT:
        out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> hdl/priority_budget_round_robin_picker_top.sv
`timescale 1ns / 1ps
// Set operations and unused opcodes go from SCAN straight to OUT, where the result is offered.
// A pick works levels 3 down to 1: per level SCAN searches and REFILL checks, or, where a refill
// and a second search follow, RESCAN and LVL0 come next; level 0 is taken in the last check.
// One item is in work at a time; after the result transfer the block returns to IDLE.
// Reset (asynchronous, active low) clears all flags and pointers, sets every
// entry to level 2 with budget 16 and loads the budget registers with 32, 16, 8.
module priority_budget_round_robin_picker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [pbrr_pkg::IdxW-1:0]     entry_index_i,
  input  logic                          runnable_value_i,
  input  logic [pbrr_pkg::LvlW-1:0]     new_priority_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pick_found_o,
  output logic [pbrr_pkg::IdxW-1:0]     picked_index_o,
  output logic [pbrr_pkg::LvlW-1:0]     picked_priority_o,
  output logic [pbrr_pkg::BudW-1:0]     budget_left_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [pbrr_pkg::BudW-1:0]     cfg_data_i
);
  logic [pbrr_pkg::BudW-1:0] bud_one_q, bud_two_q, bud_three_q;
  pbrr_pkg::cmd_t cmd;
  pbrr_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bud_one_q   <= 6'd32;
      bud_two_q   <= 6'd16;
      bud_three_q <= 6'd8;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pbrr_pkg::CFG_BUD_ONE)   bud_one_q   <= cfg_data_i;
      if (cfg_idx_i == pbrr_pkg::CFG_BUD_TWO)   bud_two_q   <= cfg_data_i;
      if (cfg_idx_i == pbrr_pkg::CFG_BUD_THREE) bud_three_q <= cfg_data_i;
    end
  end

  pbrr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pbrr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .entry_index_i, .runnable_value_i, .new_priority_i,
    .bud_one_i(bud_one_q), .bud_two_i(bud_two_q), .bud_three_i(bud_three_q),
    .pick_found_o, .picked_index_o, .picked_priority_o, .budget_left_o
  );

`ifndef ASSERT_OFF
  // Never ready for input while a result is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("ready and result valid together");
  // A result with nothing found carries a zero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !pick_found_o |-> picked_index_o == '0)
    else $error("index without a find");
  // Level 0 winners carry no budget.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && picked_priority_o == '0 |-> budget_left_o == '0)
    else $error("budget on level 0 pick");
`endif

endmodule

>>> verif/tb_priority_budget_round_robin_picker_top.sv
`timescale 1ns / 1ps
module tb_priority_budget_round_robin_picker_top;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold  = 400;

  typedef struct packed {
    logic                      found;
    logic [pbrr_pkg::IdxW-1:0] idx;
    logic [pbrr_pkg::LvlW-1:0] lvl;
    logic [pbrr_pkg::BudW-1:0] bud;
  } pick_t;

  typedef struct packed {
    pbrr_pkg::op_e             op;
    logic [pbrr_pkg::IdxW-1:0] idx;
    logic                      run;
    logic [pbrr_pkg::LvlW-1:0] prio;
    logic                      typed;
    pick_t                     res;
  } row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  pbrr_pkg::op_e             opcode_i = pbrr_pkg::OP_SET_RUN;
  logic [pbrr_pkg::IdxW-1:0] entry_index_i = '0;
  logic                      runnable_value_i = 1'b0;
  logic [pbrr_pkg::LvlW-1:0] new_priority_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      pick_found_o;
  logic [pbrr_pkg::IdxW-1:0] picked_index_o;
  logic [pbrr_pkg::LvlW-1:0] picked_priority_o;
  logic [pbrr_pkg::BudW-1:0] budget_left_o;
  logic                      cfg_we_i = 1'b0;
  logic [1:0]                cfg_idx_i = pbrr_pkg::CFG_BUD_ONE;
  logic [pbrr_pkg::BudW-1:0] cfg_data_i = '0;

  // Side information travelling with the item on the input channel.
  logic            item_typed = 1'b0;
  pick_t           item_res = '0;

  priority_budget_round_robin_picker_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .entry_index_i,
    .runnable_value_i, .new_priority_i, .out_valid_o, .out_ready_i,
    .pick_found_o, .picked_index_o, .picked_priority_o, .budget_left_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mirror of the scheduler state.
  logic                      mdl_run  [pbrr_pkg::NumEntries];
  logic [pbrr_pkg::LvlW-1:0] mdl_prio [pbrr_pkg::NumEntries];
  logic [pbrr_pkg::BudW-1:0] mdl_bud  [pbrr_pkg::NumEntries];
  logic [pbrr_pkg::IdxW-1:0] mdl_ptr  [pbrr_pkg::NumLevels];
  logic [pbrr_pkg::BudW-1:0] mdl_load [pbrr_pkg::NumLevels];

  pick_t pick_q [$];
  int    mismatches = 0;
  bit    sender_burst = 1'b0;
  bit    receiver_burst = 1'b0;

  function automatic logic [pbrr_pkg::BudW-1:0] level_load(logic [pbrr_pkg::LvlW-1:0] lvl);
    return (lvl == 0) ? '0 : mdl_load[lvl];
  endfunction

  function automatic int find_in_level(int lvl);
    int k;
    for (int i = 0; i < pbrr_pkg::NumEntries; i++) begin
      k = (mdl_ptr[lvl] + i) % pbrr_pkg::NumEntries;
      if (mdl_run[k] && mdl_prio[k] == lvl && mdl_bud[k] != 0) return k;
    end
    return -1;
  endfunction

  function automatic pick_t schedule_step(pbrr_pkg::op_e op, logic [pbrr_pkg::IdxW-1:0] idx,
                                          logic run, logic [pbrr_pkg::LvlW-1:0] prio);
    pick_t r;
    int    w;
    int    nxt;
    bit    any;
    r = '0;
    case (op)
      pbrr_pkg::OP_SET_RUN: mdl_run[idx] = run;
      pbrr_pkg::OP_SET_PRIO: begin
        mdl_prio[idx] = prio;
        mdl_bud[idx]  = level_load(prio);
      end
      pbrr_pkg::OP_PICK: begin
        for (int lvl = 3; lvl >= 1; lvl--) begin
          w = find_in_level(lvl);
          if (w < 0) begin
            any = 1'b0;
            for (int k = 0; k < pbrr_pkg::NumEntries; k++) begin
              if (mdl_run[k] && mdl_prio[k] == lvl) begin
                any = 1'b1;
                if (mdl_bud[k] == 0) mdl_bud[k] = level_load(lvl[pbrr_pkg::LvlW-1:0]);
              end
            end
            if (any) w = find_in_level(lvl);
          end
          if (w >= 0) begin
            mdl_bud[w] = mdl_bud[w] - 1'b1;
            nxt = (w + 1) % pbrr_pkg::NumEntries;
            mdl_ptr[lvl] = nxt[pbrr_pkg::IdxW-1:0];
            r.found = 1'b1;
            r.idx = w[pbrr_pkg::IdxW-1:0];
            r.lvl = lvl[pbrr_pkg::LvlW-1:0];
            r.bud = mdl_bud[w];
            return r;
          end
        end
        for (int k = 0; k < pbrr_pkg::NumEntries; k++) begin
          if (mdl_run[k] && mdl_prio[k] == 0) begin
            r.found = 1'b1;
            r.idx = k[pbrr_pkg::IdxW-1:0];
            return r;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    for (int k = 0; k < pbrr_pkg::NumEntries; k++) begin
      mdl_run[k] = 1'b0;
      mdl_prio[k] = 2'd2;
      mdl_bud[k] = 6'd16;
    end
    for (int l = 0; l < pbrr_pkg::NumLevels; l++) mdl_ptr[l] = '0;
    mdl_load[0] = 6'd0;
    mdl_load[1] = 6'd32;
    mdl_load[2] = 6'd16;
    mdl_load[3] = 6'd8;
  end

  // Transfer monitor, checker and watchdog.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    pick_t exp_r, got, pred;
    if (in_valid_i && in_ready_o) begin
      pred = schedule_step(opcode_i, entry_index_i, runnable_value_i, new_priority_i);
      pick_q.push_back(item_typed ? item_res : pred);
    end
    if (out_valid_o && out_ready_i) begin
      got = '{pick_found_o, picked_index_o, picked_priority_o, budget_left_o};
      if (pick_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %p", got);
      end else begin
        exp_r = pick_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%0d idx=%0d lvl=%0d bud=%0d, got %0d %0d %0d %0d",
                     exp_r.found, exp_r.idx, exp_r.lvl, exp_r.bud,
                     got.found, got.idx, got.lvl, got.bud);
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IdleLimit) begin
      $display("tb_priority_budget_round_robin_picker_top: errors");
      $finish;
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off.
  initial begin
    int stall;
    int rx_count;
    stall = 0;
    rx_count = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      if (out_ready_i && out_valid_o) begin
        rx_count++;
        if (rx_count % 40 == 0) receiver_burst = ($urandom_range(0, 2) == 0);
        stall = receiver_burst ? 0 : $urandom_range(0, 18);
        if (rx_count == 300) stall = LongHold;
      end else if (stall > 0) begin
        stall--;
      end
      out_ready_i <= (stall == 0);
    end
  end

  task automatic wait_drained();
    @(posedge clk_i);
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (15) @(posedge clk_i);
  endtask

  task automatic write_budgets(logic [pbrr_pkg::BudW-1:0] b1, logic [pbrr_pkg::BudW-1:0] b2,
                               logic [pbrr_pkg::BudW-1:0] b3);
    logic [1:0] regs [3];
    logic [pbrr_pkg::BudW-1:0] vals [3];
    regs = '{pbrr_pkg::CFG_BUD_ONE, pbrr_pkg::CFG_BUD_TWO, pbrr_pkg::CFG_BUD_THREE};
    vals = '{b1, b2, b3};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[i];
      cfg_data_i <= vals[i];
      mdl_load[i + 1] = vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offers one item, holding valid across back-to-back transfers.
  task automatic offer(row_t r);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= r.op;
    entry_index_i <= r.idx;
    runnable_value_i <= r.run;
    new_priority_i <= r.prio;
    item_typed <= r.typed;
    item_res <= r.res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic row_t random_item();
    row_t r;
    int sel;
    r = '0;
    sel = $urandom_range(0, 99);
    r.op = (sel < 40) ? pbrr_pkg::OP_PICK : (sel < 70) ? pbrr_pkg::OP_SET_RUN :
           (sel < 95) ? pbrr_pkg::OP_SET_PRIO : pbrr_pkg::OP_NONE;
    // Most items work a small group of entries so that levels fill and drain.
    case ($urandom_range(0, 3))
      0: r.idx = 6'($urandom_range(0, 63));
      1: r.idx = 6'($urandom_range(56, 63));
      default: r.idx = 6'($urandom_range(0, 7));
    endcase
    r.run = ($urandom_range(0, 3) != 0);
    r.prio = 2'($urandom_range(0, 3));
    return r;
  endfunction

  row_t directed [] = '{
    '{pbrr_pkg::OP_PICK,     6'd0,  1'b0, 2'd0, 1'b1, '{1'b0, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_NONE,     6'd63, 1'b1, 2'd3, 1'b1, '{1'b0, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_SET_RUN,  6'd63, 1'b1, 2'd0, 1'b1, '{1'b0, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_PICK,     6'd0,  1'b0, 2'd0, 1'b1, '{1'b1, 6'd63, 2'd2, 6'd15}},
    '{pbrr_pkg::OP_SET_PRIO, 6'd63, 1'b0, 2'd3, 1'b1, '{1'b0, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_PICK,     6'd0,  1'b0, 2'd0, 1'b1, '{1'b1, 6'd63, 2'd3, 6'd7}},
    '{pbrr_pkg::OP_SET_RUN,  6'd0,  1'b1, 2'd0, 1'b1, '{1'b0, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_SET_PRIO, 6'd0,  1'b0, 2'd0, 1'b1, '{1'b0, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_SET_RUN,  6'd63, 1'b0, 2'd0, 1'b1, '{1'b0, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_PICK,     6'd0,  1'b0, 2'd0, 1'b1, '{1'b1, 6'd0,  2'd0, 6'd0}},
    '{pbrr_pkg::OP_SET_PRIO, 6'd1,  1'b0, 2'd1, 1'b0, '0},
    '{pbrr_pkg::OP_SET_RUN,  6'd1,  1'b1, 2'd0, 1'b0, '0},
    '{pbrr_pkg::OP_PICK,     6'd0,  1'b0, 2'd0, 1'b1, '{1'b1, 6'd1,  2'd1, 6'd31}},
    '{pbrr_pkg::OP_SET_RUN,  6'd63, 1'b1, 2'd0, 1'b0, '0},
    '{pbrr_pkg::OP_PICK,     6'd42, 1'b1, 2'd3, 1'b0, '0},
    '{pbrr_pkg::OP_SET_PRIO, 6'd21, 1'b1, 2'd2, 1'b0, '0},
    '{pbrr_pkg::OP_SET_RUN,  6'd21, 1'b1, 2'd1, 1'b0, '0},
    '{pbrr_pkg::OP_PICK,     6'd0,  1'b0, 2'd0, 1'b0, '0},
    '{pbrr_pkg::OP_SET_PRIO, 6'd63, 1'b0, 2'd2, 1'b0, '0},
    '{pbrr_pkg::OP_PICK,     6'd0,  1'b0, 2'd0, 1'b0, '0}
  };

  logic [pbrr_pkg::BudW-1:0] budget_sets [5][3] = '{
    '{6'd1,  6'd1,  6'd1},
    '{6'd63, 6'd63, 6'd63},
    '{6'd0,  6'd5,  6'd0},   // zero budgets make refills come up empty
    '{6'd2,  6'd0,  6'd3},
    '{6'd32, 6'd16, 6'd8}
  };

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) offer(directed[i]);
    for (int p = 0; p < 5; p++) begin
      in_valid_i <= 1'b0;
      item_typed <= 1'b0;
      wait_drained();
      if (p == 3)
        write_budgets(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
      else
        write_budgets(budget_sets[p][0], budget_sets[p][1], budget_sets[p][2]);
      for (int n = 0; n < 160; n++) begin
        if (n % 30 == 0) sender_burst = ($urandom_range(0, 2) == 0);
        offer(random_item());
      end
    end
    in_valid_i <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("tb_priority_budget_round_robin_picker_top: clean");
    end else begin
      $display("tb_priority_budget_round_robin_picker_top: errors");
    end
    $finish;
  end

endmodule

>>> priority_budget_round_robin_picker_top.f
hdl/pbrr_pkg.sv
hdl/pbrr_datapath.sv
hdl/pbrr_ctrl.sv
hdl/priority_budget_round_robin_picker_top.sv
verif/tb_priority_budget_round_robin_picker_top.sv
